[src/lsrte_pkg.sv]
package lsrte_pkg;

  localparam int BUCKETS     = 10;
  localparam int SLOTS       = 3;
  localparam int PATH_LEN    = 10;
  localparam int BUCKET_SPAN = 1000;

  localparam int ENTRIES     = BUCKETS * SLOTS;
  localparam int SETTLED_MAX = PATH_LEN - 1;

  localparam int NODE_W   = 14;
  localparam int COST_W   = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BASE_W = $clog2(ENTRIES + 1);
  localparam int BKT_W  = $clog2(BUCKETS + 1);
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int PIDX_W = (SETTLED_MAX > 1) ? $clog2(SETTLED_MAX) : 1;
  localparam int CNT_W  = $clog2(SETTLED_MAX + 1);

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADVERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SELECT = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_IMPROVED  = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] dest;
    logic [NODE_W-1:0] link;
    logic [COST_W-1:0] metric;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [NODE_W-1:0] chosen_dest;
    logic [COST_W-1:0] chosen_metric;
  } out_item_t;

endpackage

[src/link_state_route_table_engine_unit.sv]
// Link-state route table engine: one step of a shortest-path search per item.
// An item is taken on in_data when start is high and busy is low. Kind 0 loads
// an own link entry, kind 1 relaxes a neighbor advertisement against the last
// chosen node, kind 2 settles the cheapest unvisited entry while the path has room.
// Every item gives exactly one result on out_data, shown for one cycle with
// out_valid high; the receiver has no way to stall it.
// The own node identifier is written through cfg_data with cfg_valid and
// cfg_ready; cfg_ready is high whenever busy is low.
// One compare and subtract unit and one table read port are walked by a small
// sequencer. A load finds its bucket by repeated subtraction of the bucket span
// and then probes the slots of that bucket in order. An advertisement first
// walks the settled path, then finds the bucket and probes its slots as a load
// does. A select walks all table entries. Items that decide at once (unused
// kind, own node) give their result straight from the idle state. Busy stays
// high until the result cycle, in which the next item may start.
// Reset clears the table valid bits, the path and the last chosen node.
module link_state_route_table_engine_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lsrte_pkg::in_item_t       in_data,
  output logic                      out_valid,
  output lsrte_pkg::out_item_t      out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lsrte_pkg::NODE_W-1:0] cfg_data
);
  import lsrte_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PATH, S_DIV, S_SLOT, S_SEL} state_t;

  state_t            state_r;
  in_item_t          item_r;
  logic [NODE_W-1:0] own_node_r;
  logic [COST_W-1:0] sum_r;
  logic [NODE_W-1:0] rem_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [BASE_W-1:0] base_r;
  logic [SLOT_W-1:0] slot_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  scan_r;
  logic [CNT_W-1:0]  count_r;
  logic [NODE_W-1:0] last_dest_r;
  logic [COST_W-1:0] last_cost_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [COST_W-1:0] best_cost_r;
  logic [NODE_W-1:0] best_dest_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] visited_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [NODE_W-1:0] dest_mem_r [ENTRIES];
  logic [NODE_W-1:0] hop_mem_r  [ENTRIES];
  logic [COST_W-1:0] cost_mem_r [ENTRIES];
  logic [NODE_W-1:0] path_mem_r [SETTLED_MAX];

  logic              accept_w;
  logic [COST_W:0]   raw_sum_w;
  logic [COST_W-1:0] sat_sum_w;
  logic              slot_live_w;
  logic              ins_w;
  logic              match_w;
  logic              upd_w;
  logic              cand_w;
  logic              take_w;
  logic              fin_found_w;
  logic [IDX_W-1:0]  fin_idx_w;
  logic [COST_W-1:0] fin_cost_w;
  logic [NODE_W-1:0] fin_dest_w;
  logic              sel_done_w;
  logic              path_full_w;
  logic              commit_w;
  logic              div_step_w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = ~busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign accept_w  = start & ~busy;

  always_comb begin
    raw_sum_w   = {1'b0, in_data.metric} + {1'b0, last_cost_r};
    sat_sum_w   = raw_sum_w[COST_W] ? {COST_W{1'b1}} : raw_sum_w[COST_W-1:0];
    div_step_w  = ({2'b00, rem_r} >= COST_W'(BUCKET_SPAN)) && (bkt_r != BKT_W'(BUCKETS));
    slot_live_w = (state_r == S_SLOT) && (slot_r != SLOT_W'(SLOTS));
    ins_w       = slot_live_w && !valid_r[idx_r];
    match_w     = slot_live_w && valid_r[idx_r] && (item_r.kind == KIND_ADVERT) &&
                  (dest_mem_r[idx_r] == item_r.dest);
    upd_w       = match_w && (cost_mem_r[idx_r] > sum_r);
    cand_w      = valid_r[idx_r] && !visited_r[idx_r];
    take_w      = cand_w && (!found_r || (cost_mem_r[idx_r] < best_cost_r));
    fin_found_w = found_r || take_w;
    fin_idx_w   = take_w ? idx_r : best_idx_r;
    fin_cost_w  = take_w ? cost_mem_r[idx_r] : best_cost_r;
    fin_dest_w  = take_w ? dest_mem_r[idx_r] : best_dest_r;
    sel_done_w  = (state_r == S_SEL) && (idx_r == IDX_W'(ENTRIES - 1));
    path_full_w = (count_r >= CNT_W'(SETTLED_MAX));
    commit_w    = sel_done_w && fin_found_w && !path_full_w;
  end

  always_ff @(posedge clk) begin
    if (ins_w) begin
      dest_mem_r[idx_r] <= item_r.dest;
      hop_mem_r[idx_r]  <= (item_r.kind == KIND_LOAD) ? item_r.link : last_dest_r;
      cost_mem_r[idx_r] <= (item_r.kind == KIND_LOAD) ? item_r.metric : sum_r;
    end else if (upd_w) begin
      hop_mem_r[idx_r]  <= last_dest_r;
      cost_mem_r[idx_r] <= sum_r;
    end
    if (commit_w) begin
      path_mem_r[count_r[PIDX_W-1:0]] <= fin_dest_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      own_node_r  <= '0;
      count_r     <= '0;
      last_dest_r <= '0;
      last_cost_r <= '0;
      valid_r     <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        own_node_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept_w) begin
            item_r  <= in_data;
            sum_r   <= sat_sum_w;
            rem_r   <= in_data.dest;
            bkt_r   <= '0;
            base_r  <= '0;
            scan_r  <= '0;
            idx_r   <= '0;
            found_r <= 1'b0;
            priority if (in_data.kind == KIND_LOAD) begin
              state_r <= S_DIV;
            end else if (in_data.kind == KIND_ADVERT && in_data.dest != own_node_r) begin
              state_r <= S_PATH;
            end else if (in_data.kind == KIND_SELECT) begin
              state_r <= S_SEL;
            end else begin
              out_valid_r          <= 1'b1;
              out_r.status         <= ST_UNCHANGED;
              out_r.chosen_dest    <= last_dest_r;
              out_r.chosen_metric  <= last_cost_r;
            end
          end
        end
        S_PATH: begin
          if (scan_r == count_r) begin
            state_r <= S_DIV;
          end else if (path_mem_r[scan_r[PIDX_W-1:0]] == item_r.dest) begin
            state_r             <= S_IDLE;
            out_valid_r         <= 1'b1;
            out_r.status        <= ST_UNCHANGED;
            out_r.chosen_dest   <= last_dest_r;
            out_r.chosen_metric <= last_cost_r;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_step_w) begin
            rem_r  <= rem_r - NODE_W'(BUCKET_SPAN);
            bkt_r  <= bkt_r + 1'b1;
            base_r <= base_r + BASE_W'(SLOTS);
          end else if (bkt_r == BKT_W'(BUCKETS)) begin
            state_r             <= S_IDLE;
            out_valid_r         <= 1'b1;
            out_r.status        <= ST_FULL;
            out_r.chosen_dest   <= last_dest_r;
            out_r.chosen_metric <= last_cost_r;
          end else begin
            state_r <= S_SLOT;
            slot_r  <= '0;
            idx_r   <= base_r[IDX_W-1:0];
          end
        end
        S_SLOT: begin
          priority if (!slot_live_w) begin
            state_r             <= S_IDLE;
            out_valid_r         <= 1'b1;
            out_r.status        <= ST_FULL;
            out_r.chosen_dest   <= last_dest_r;
            out_r.chosen_metric <= last_cost_r;
          end else if (ins_w) begin
            valid_r[idx_r]      <= 1'b1;
            visited_r[idx_r]    <= 1'b0;
            state_r             <= S_IDLE;
            out_valid_r         <= 1'b1;
            out_r.status        <= ST_OK;
            out_r.chosen_dest   <= last_dest_r;
            out_r.chosen_metric <= last_cost_r;
          end else if (match_w) begin
            state_r             <= S_IDLE;
            out_valid_r         <= 1'b1;
            out_r.status        <= upd_w ? ST_IMPROVED : ST_UNCHANGED;
            out_r.chosen_dest   <= last_dest_r;
            out_r.chosen_metric <= last_cost_r;
          end else begin
            slot_r <= slot_r + 1'b1;
            idx_r  <= idx_r + 1'b1;
          end
        end
        S_SEL: begin
          if (take_w) begin
            found_r     <= 1'b1;
            best_idx_r  <= idx_r;
            best_cost_r <= cost_mem_r[idx_r];
            best_dest_r <= dest_mem_r[idx_r];
          end
          if (sel_done_w) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            priority if (!fin_found_w) begin
              last_dest_r         <= '0;
              last_cost_r         <= '0;
              out_r.status        <= ST_EMPTY;
              out_r.chosen_dest   <= '0;
              out_r.chosen_metric <= '0;
            end else if (path_full_w) begin
              out_r.status        <= ST_FULL;
              out_r.chosen_dest   <= last_dest_r;
              out_r.chosen_metric <= last_cost_r;
            end else begin
              visited_r[fin_idx_w] <= 1'b1;
              count_r              <= count_r + 1'b1;
              last_dest_r          <= fin_dest_w;
              last_cost_r          <= fin_cost_w;
              out_r.status         <= ST_OK;
              out_r.chosen_dest    <= fin_dest_w;
              out_r.chosen_metric  <= fin_cost_w;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[bench/tb.sv]
module tb;
  import lsrte_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOT_COUNT = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [NODE_W-1:0] cfg_data = '0;

  link_state_route_table_engine_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Route table model state.
  logic              route_valid [ENTRIES] = '{default: 1'b0};
  logic              route_seen  [ENTRIES] = '{default: 1'b0};
  logic [NODE_W-1:0] route_dest  [ENTRIES] = '{default: '0};
  logic [NODE_W-1:0] route_hop   [ENTRIES] = '{default: '0};
  logic [COST_W-1:0] route_cost  [ENTRIES] = '{default: '0};
  logic [NODE_W-1:0] settled     [SETTLED_MAX] = '{default: '0};
  int                settled_n = 0;
  logic [NODE_W-1:0] last_node = '0;
  logic [COST_W-1:0] last_metric = '0;
  logic [NODE_W-1:0] own_id = '0;

  in_item_t  route_items [$];
  out_item_t route_replies [$];
  int        hot_nodes [HOT_COUNT];
  int        n_queued = 0;
  int        n_done = 0;
  int        n_accepted = 0;
  int        mismatches = 0;
  int        status_tally [8] = '{default: 0};
  int        quiet = 0;
  int        gap_left = 0;
  logic      idle_on = 1'b1;
  logic      in_fire = 1'b0;
  logic      cfg_fire = 1'b0;

  function automatic int home_bucket(logic [NODE_W-1:0] d);
    int b;
    b = int'(d) / BUCKET_SPAN;
    return (b < BUCKETS) ? b : BUCKETS;
  endfunction

  function automatic int find_route(logic [NODE_W-1:0] d);
    int b;
    b = home_bucket(d);
    if (b < BUCKETS) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!route_valid[b * SLOTS + s]) return ENTRIES;
        if (route_dest[b * SLOTS + s] == d) return b * SLOTS + s;
      end
    end
    return ENTRIES;
  endfunction

  function automatic status_t add_route(logic [NODE_W-1:0] d, logic [NODE_W-1:0] hop,
                                        logic [COST_W-1:0] cost);
    int b;
    b = home_bucket(d);
    if (b >= BUCKETS) return ST_FULL;
    for (int s = 0; s < SLOTS; s++) begin
      if (!route_valid[b * SLOTS + s]) begin
        route_valid[b * SLOTS + s] = 1'b1;
        route_seen[b * SLOTS + s]  = 1'b0;
        route_dest[b * SLOTS + s]  = d;
        route_hop[b * SLOTS + s]   = hop;
        route_cost[b * SLOTS + s]  = cost;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic out_item_t route_step(in_item_t it);
    out_item_t r;
    status_t st;
    int idx;
    int best;
    logic found;
    logic hit;
    logic [COST_W:0] sum;
    logic [COST_W-1:0] cost;
    case (it.kind)
      KIND_LOAD: st = add_route(it.dest, it.link, it.metric);
      KIND_ADVERT: begin
        hit = (it.dest == own_id);
        for (int k = 0; k < settled_n; k++)
          if (settled[k] == it.dest) hit = 1'b1;
        if (hit) begin
          st = ST_UNCHANGED;
        end else begin
          sum = {1'b0, it.metric} + {1'b0, last_metric};
          cost = sum[COST_W] ? '1 : sum[COST_W-1:0];
          idx = find_route(it.dest);
          if (idx == ENTRIES) begin
            st = add_route(it.dest, last_node, cost);
          end else if (route_cost[idx] > cost) begin
            route_hop[idx] = last_node;
            route_cost[idx] = cost;
            st = ST_IMPROVED;
          end else begin
            st = ST_UNCHANGED;
          end
        end
      end
      KIND_SELECT: begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (route_valid[i] && !route_seen[i] &&
              (!found || route_cost[i] < route_cost[best])) begin
            best = i;
            found = 1'b1;
          end
        if (!found) begin
          last_node = '0;
          last_metric = '0;
          st = ST_EMPTY;
        end else if (settled_n >= SETTLED_MAX) begin
          st = ST_FULL;
        end else begin
          route_seen[best] = 1'b1;
          settled[settled_n] = route_dest[best];
          settled_n++;
          last_node = route_dest[best];
          last_metric = route_cost[best];
          st = ST_OK;
        end
      end
      default: st = ST_UNCHANGED;
    endcase
    r.status = st;
    r.chosen_dest = last_node;
    r.chosen_metric = last_metric;
    return r;
  endfunction

  always @(negedge clk) begin : drive
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_fire) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (route_items.size() > 0) begin
        in_data <= route_items.pop_front();
        start <= 1'b1;
        if (!idle_on || r < 55) gap_left <= 0;
        else if (r < 90) gap_left <= $urandom_range(1, 3);
        else gap_left <= $urandom_range(4, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : observe
    out_item_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
      quiet <= 0;
    end else begin
      in_fire <= start && !busy;
      cfg_fire <= cfg_valid && cfg_ready;
      if (start && !busy) begin
        route_replies.push_back(route_step(in_data));
        n_accepted++;
      end
      if (cfg_valid && cfg_ready) own_id = cfg_data;
      if (out_valid) begin
        status_tally[out_data.status]++;
        if (route_replies.size() == 0) begin
          $error("Result with no prediction pending: status %0d dest %0d metric %0d",
                 out_data.status, out_data.chosen_dest, out_data.chosen_metric);
          mismatches++;
        end else begin
          want = route_replies.pop_front();
          n_done++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.chosen_dest !== want.chosen_dest) begin
            $error("chosen_dest: expected %0d, actual %0d",
                   want.chosen_dest, out_data.chosen_dest);
            mismatches++;
          end
          if (out_data.chosen_metric !== want.chosen_metric) begin
            $error("chosen_metric: expected %0d, actual %0d",
                   want.chosen_metric, out_data.chosen_metric);
            mismatches++;
          end
        end
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $error("No transfer for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic queue_item(logic [KIND_W-1:0] k, logic [NODE_W-1:0] d,
                            logic [NODE_W-1:0] l, logic [COST_W-1:0] m);
    in_item_t it;
    it.kind = k;
    it.dest = d;
    it.link = l;
    it.metric = m;
    route_items.push_back(it);
    n_queued++;
  endtask

  task automatic settle();
    while (n_done != n_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_own_node(logic [NODE_W-1:0] id);
    settle();
    cfg_data <= id;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  // Most traffic targets a fixed set of destinations so that lookups hit,
  // buckets fill up and advertisements can improve routes.
  task automatic queue_random(int n, logic [NODE_W-1:0] own);
    int r;
    logic [KIND_W-1:0] k;
    logic [NODE_W-1:0] d;
    logic [COST_W-1:0] m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) k = KIND_LOAD;
      else if (r < 70) k = KIND_ADVERT;
      else if (r < 93) k = KIND_SELECT;
      else k = KIND_SPARE;
      r = $urandom_range(0, 99);
      if (r < 60) d = NODE_W'(hot_nodes[$urandom_range(0, HOT_COUNT - 1)]);
      else if (r < 70) d = own;
      else if (r < 90) d = NODE_W'($urandom_range(0, 9999));
      else d = NODE_W'($urandom_range(10000, 16383));
      r = $urandom_range(0, 99);
      if (r < 60) m = COST_W'($urandom_range(0, 200));
      else if (r < 80) m = COST_W'($urandom_range(0, 65535));
      else if (r < 90) m = '1;
      else m = '0;
      queue_item(k, d, NODE_W'($urandom_range(0, 16383)), m);
    end
  endtask

  initial begin : stimulus
    logic [NODE_W-1:0] own;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    for (int b = 0; b < BUCKETS; b++) begin
      hot_nodes[2 * b] = b * BUCKET_SPAN + $urandom_range(0, BUCKET_SPAN - 1);
      hot_nodes[2 * b + 1] = b * BUCKET_SPAN + $urandom_range(0, BUCKET_SPAN - 1);
    end
    hot_nodes[20] = 5;
    hot_nodes[21] = 999;
    hot_nodes[22] = 500;
    hot_nodes[23] = 1005;

    set_own_node('0);
    queue_item(KIND_SELECT, 14'd16383, 14'd16383, 16'hffff);
    queue_item(KIND_SPARE, 14'd16383, 14'd16383, 16'hffff);
    queue_item(KIND_ADVERT, 14'd0, 14'd0, 16'd5);
    queue_item(KIND_LOAD, 14'd5, 14'd16383, 16'd0);
    queue_item(KIND_SELECT, 14'd0, 14'd0, 16'd0);
    queue_item(KIND_SELECT, 14'd0, 14'd0, 16'd0);
    queue_item(KIND_ADVERT, 14'd5, 14'd0, 16'd1);
    queue_item(KIND_LOAD, 14'd999, 14'd0, 16'd100);
    queue_item(KIND_LOAD, 14'd500, 14'd3, 16'd7);
    queue_item(KIND_LOAD, 14'd42, 14'd4, 16'd1);
    queue_item(KIND_LOAD, 14'd10000, 14'd1, 16'd1);
    queue_item(KIND_ADVERT, 14'd16383, 14'd0, 16'd1);
    queue_item(KIND_LOAD, 14'd1005, 14'd9999, 16'hffff);
    queue_item(KIND_SELECT, 14'd0, 14'd0, 16'd0);
    queue_item(KIND_ADVERT, 14'd999, 14'd0, 16'd50);
    queue_item(KIND_ADVERT, 14'd999, 14'd0, 16'd60);
    queue_item(KIND_ADVERT, 14'd9999, 14'd0, 16'hffff);
    queue_item(KIND_ADVERT, 14'd1005, 14'd0, 16'hffff);
    queue_item(KIND_LOAD, 14'd2000, 14'd7, 16'd57);
    queue_item(KIND_LOAD, 14'd3000, 14'd8, 16'd57);
    queue_item(KIND_SELECT, 14'd0, 14'd0, 16'd0);
    queue_item(KIND_SELECT, 14'd0, 14'd0, 16'd0);
    queue_item(KIND_ADVERT, 14'd3000, 14'd0, 16'd0);
    queue_item(KIND_ADVERT, 14'd8000, 14'd0, 16'd0);

    set_own_node(14'd9999);
    queue_random(250, 14'd9999);

    own = NODE_W'($urandom_range(0, 16383));
    set_own_node(own);
    idle_on <= 1'b0;
    queue_random(250, own);

    set_own_node('0);
    idle_on <= 1'b1;
    queue_random(250, '0);

    settle();
    if (route_replies.size() != 0) begin
      $error("%0d predicted results never arrived", route_replies.size());
      mismatches++;
    end
    $display("Covered %0d transfers under four own-node settings, with random idle gaps.",
             n_accepted);
    $display("Result mix: inserted/selected %0d, improved %0d, unchanged %0d, full %0d, empty %0d",
             status_tally[ST_OK], status_tally[ST_IMPROVED], status_tally[ST_UNCHANGED],
             status_tally[ST_FULL], status_tally[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
